// ----- hdl/dics_pkg.sv -----
// ----------------------------------------------------------------------------
// dics_pkg: shared types and constants for the inverse-CDF sampler
// Table geometry, field widths, command and status codes, and the request
// bundle that the sequencer sends to the cumulative table memory.
// ----------------------------------------------------------------------------
package dics_pkg;

	localparam int MAX_EVENTS = 256;
	localparam int IDX_W      = $clog2(MAX_EVENTS);
	localparam int CNT_W      = $clog2(MAX_EVENTS + 1);
	localparam int PROB_BITS  = 16;
	localparam int TOTAL_BITS = 24;
	localparam int OUT_IDX_W  = 8;
	localparam int STATUS_W   = 2;

	localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = {TOTAL_BITS{1'b1}};

	localparam logic CMD_LOAD   = 1'b0;
	localparam logic CMD_SAMPLE = 1'b1;

	localparam logic [STATUS_W-1:0] STAT_LOADED  = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_SAMPLED = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_FULL    = 2'd2;
	localparam logic [STATUS_W-1:0] STAT_EMPTY   = 2'd3;

	typedef logic [IDX_W-1:0]      idx_t;
	typedef logic [CNT_W-1:0]      cnt_t;
	typedef logic [TOTAL_BITS-1:0] total_t;
	typedef logic [PROB_BITS-1:0]  prob_t;

	// Write and read request to the cumulative table.
	typedef struct packed {
		logic   we;
		idx_t   waddr;
		total_t wdata;
		idx_t   raddr;
	} mem_req_t;

endpackage

// ----- hdl/discrete_inverse_cdf_sampler.sv -----
// ----------------------------------------------------------------------------
// discrete_inverse_cdf_sampler: table-driven discrete event sampler
// Builds a cumulative weight table and draws event indices from it.
// ----------------------------------------------------------------------------
// Usage. A command transfer happens at a rising edge where start is high and
// busy is low; cmd selects a load (append weight, with first_entry restarting
// the table) or a sample (draw with random_value). Every command produces one
// result transfer: done is high for exactly one cycle with event_index and
// status valid. The receiver cannot stall the block, so the result must be
// captured in that cycle.
// Timing. A load and a sample of an empty table raise done in the cycle
// after the command transfer, and busy never rises, so a command may follow
// every cycle. A sample of a non-empty table walks the table through the one
// shared comparator, one entry per cycle behind the registered memory read;
// done rises once the compare picks an entry, and busy is high through the
// walk, so no new command is taken until it ends. The registered memory read
// and the single compare unit set the pace of the walk.
// Reset. arst_n clears the entry count and running total, so the table is
// empty; the table memory itself is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module discrete_inverse_cdf_sampler (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic                           cmd,
	input  dics_pkg::prob_t                weight,
	input  logic                           first_entry,
	input  dics_pkg::prob_t                random_value,
	output logic                           done,
	output logic [dics_pkg::OUT_IDX_W-1:0] event_index,
	output logic [dics_pkg::STATUS_W-1:0]  status
);
	import dics_pkg::*;

	// Request bundle from the sequencer and read data back from the table.
	mem_req_t mem_req;
	total_t   mem_rdata;

	// The sequencer owns all control state and the single comparator.
	dics_seq u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.cmd          (cmd),
		.weight       (weight),
		.first_entry  (first_entry),
		.random_value (random_value),
		.busy         (busy),
		.done         (done),
		.event_index  (event_index),
		.status       (status),
		.mem_req      (mem_req),
		.mem_rdata    (mem_rdata)
	);

	// The cumulative table: written on each accepted load that finds room, read
	// every cycle at the walk pointer.
	dics_table u_table (
		.clk   (clk),
		.req   (mem_req),
		.rdata (mem_rdata)
	);

endmodule

// ----- hdl/dics_table.sv -----
// ----------------------------------------------------------------------------
// dics_table: cumulative sum table
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module dics_table (
	input  logic              clk,
	input  dics_pkg::mem_req_t req,
	output dics_pkg::total_t  rdata
);
	import dics_pkg::*;

	total_t mem_q [MAX_EVENTS];
	total_t rdata_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem_q[req.waddr] <= req.wdata;
		end
		rdata_q <= mem_q[req.raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- hdl/dics_seq.sv -----
// ----------------------------------------------------------------------------
// dics_seq: command sequencer with the shared compare unit
// Appends saturated prefix sums on load; on sample, streams table entries
// through one comparator until the first entry above the random value or the last.
// ----------------------------------------------------------------------------
module dics_seq (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic                              cmd,
	input  dics_pkg::prob_t                   weight,
	input  logic                              first_entry,
	input  dics_pkg::prob_t                   random_value,
	output logic                              busy,
	output logic                              done,
	output logic [dics_pkg::OUT_IDX_W-1:0]    event_index,
	output logic [dics_pkg::STATUS_W-1:0]     status,
	output dics_pkg::mem_req_t                mem_req,
	input  dics_pkg::total_t                  mem_rdata
);
	import dics_pkg::*;

	typedef enum logic {ST_IDLE, ST_WALK} state_t;

	state_t  state_q;
	cnt_t    count_q;
	total_t  total_q;
	prob_t   rnd_q;
	idx_t    addr_q;
	idx_t    cmp_idx_q;
	logic    cmp_vld_q;
	logic    done_q;
	logic [OUT_IDX_W-1:0] index_q;
	logic [STATUS_W-1:0]  status_q;

	logic                  accept;
	cnt_t                  eff_count;
	total_t                eff_total;
	logic                  full;
	logic [TOTAL_BITS:0]   sum;
	total_t                sat_sum;
	idx_t                  last_idx;
	logic                  hit;
	logic                  at_last;

	assign accept    = start && (state_q == ST_IDLE);
	assign eff_count = first_entry ? '0 : count_q;
	assign eff_total = first_entry ? '0 : total_q;
	assign full      = (eff_count == cnt_t'(MAX_EVENTS));
	assign sum       = {1'b0, eff_total} + (TOTAL_BITS + 1)'(weight);
	assign sat_sum   = sum[TOTAL_BITS] ? TOTAL_MAX : sum[TOTAL_BITS-1:0];

	// Only the lowest bits of the count matter here: the walk starts only
	// with a non-empty table, so count - 1 always fits the index.
	assign last_idx  = idx_t'(count_q - cnt_t'(1));
	assign hit       = (TOTAL_BITS'(rnd_q) < mem_rdata);
	assign at_last   = (cmp_idx_q == last_idx);

	always_comb begin
		mem_req.we    = accept && (cmd == CMD_LOAD) && !full;
		mem_req.waddr = eff_count[IDX_W-1:0];
		mem_req.wdata = sat_sum;
		mem_req.raddr = addr_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			count_q   <= '0;
			total_q   <= '0;
			cmp_vld_q <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (cmd == CMD_LOAD) begin
							done_q <= 1'b1;
							if (full) begin
								index_q  <= '0;
								status_q <= STAT_FULL;
								count_q  <= eff_count;
								total_q  <= eff_total;
							end else begin
								index_q  <= OUT_IDX_W'(eff_count);
								status_q <= STAT_LOADED;
								count_q  <= eff_count + cnt_t'(1);
								total_q  <= sat_sum;
							end
						end else if (count_q == '0) begin
							done_q   <= 1'b1;
							index_q  <= '0;
							status_q <= STAT_EMPTY;
						end else begin
							state_q   <= ST_WALK;
							rnd_q     <= random_value;
							addr_q    <= '0;
							cmp_vld_q <= 1'b0;
						end
					end
				end
				ST_WALK: begin
					addr_q    <= addr_q + idx_t'(1);
					cmp_idx_q <= addr_q;
					cmp_vld_q <= 1'b1;
					if (cmp_vld_q && (hit || at_last)) begin
						state_q   <= ST_IDLE;
						cmp_vld_q <= 1'b0;
						done_q    <= 1'b1;
						index_q   <= OUT_IDX_W'(cmp_idx_q);
						status_q  <= STAT_SAMPLED;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy        = (state_q != ST_IDLE);
	assign done        = done_q;
	assign event_index = index_q;
	assign status      = status_q;

endmodule
